// File: rtl/fifo_recent_distinct_set_macros.svh
// Assertion macros for the recent distinct-value set.
// Used by fifo_recent_distinct_set.sv; expects aclk and aresetn in scope.
`ifndef FIFO_RECENT_DISTINCT_SET_MACROS_SVH
`define FIFO_RECENT_DISTINCT_SET_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define FRDS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("frds: same-cycle check failed");
// Next-cycle implication, disabled while in reset
`define FRDS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("frds: next-cycle check failed");
`else
`define FRDS_ASSERT_IMP(lbl, a, b)
`define FRDS_ASSERT_NXT(lbl, a, b)
`endif

`endif

// File: rtl/frds_pkg.sv
// Shared constants and types for the recent distinct-value set.
// No dependencies; imported by every module of the block.
`default_nettype none

package frds_pkg;

    localparam int DEPTH       = 256;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths on the ports
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int CAP_W  = 9;
    localparam int OCC_W  = 9;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W0 = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_W  = (CMP_W0 > POS_W) ? CMP_W0 : POS_W;

    // Two-level OR tree over the cells
    localparam int GROUP   = 16;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

    localparam int S_RAW_W  = DATA_W + POS_W;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W  = 1 + OCC_W + 1 + DATA_W + 1 + DATA_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CMP_W-1:0]       cmpw_t;

    typedef struct packed {
        value_t key;
        cmpw_t  sel;
        cmpw_t  count;
        logic   shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/fifo_recent_distinct_set.sv
// Recent distinct-value set with first-in first-out replacement; top level.
// Uses frds_pkg, frds_cell, frds_reduce and the assertion macro header.
//
// The block keeps up to min(capacity, 256) distinct values in a chain of
// cells, newest in cell 0. An offer (s_tuser 0) that matches a held value
// is a hit and changes nothing; a miss shifts the chain one place and puts
// the value in front, reporting the oldest value as evicted when the set is
// full. A read (s_tuser 1) returns the value at read_position, 0 = newest.
// Each request passes from acceptance through the parallel compare and
// position select in the cells, the registered two-level OR tree over the
// 256 cells, and an update step that updates the chain and loads the output
// register. A new request is taken only while the block is idle, so it does
// not take one before the last has passed its update step. The result register lets the
// next request enter while a result waits on m_tready; that request then
// holds in its update step until the output register is free.
// The store starts empty after reset with no clearing pass. Write capacity
// only while no request is in flight.
`default_nettype none
`include "fifo_recent_distinct_set_macros.svh"

module fifo_recent_distinct_set (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [frds_pkg::CAP_W-1:0]      cfg_wr_data,   // capacity
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [frds_pkg::S_DATA_W-1:0]   s_tdata,  // offered_value, read_position
    input  logic                            s_tuser,  // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // was_hit, occupancy, evicted_valid, evicted_value, entry_valid,
    // entry_value, zero fill
    output logic [frds_pkg::M_DATA_W-1:0]   m_tdata
);
    import frds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_RED1 = 5'b00100,
        ST_RED2 = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic                req_type_reg;
    value_t              key_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    fill_count_reg, fill_count_next;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    cmpw_t               cap_eff;
    cmpw_t               fill_w;
    cell_ctrl_t          ctrl;
    logic                out_free;
    logic                upd_go;
    logic                miss;

    value_t              cell_value [DEPTH];
    logic [DEPTH-1:0]    cell_hit;
    value_t              cell_pick  [DEPTH];
    logic                hit_any;
    value_t              pick_value;

    logic                was_hit, ev_valid, en_valid;
    value_t              ev_value, en_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign upd_go   = (state_reg == ST_UPD) && out_free;
    assign miss     = (req_type_reg == REQ_OFFER) && !hit_any;

    assign fill_w  = CMP_W'(fill_count_reg);
    assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);

    always_comb begin
        ctrl.key   = key_reg;
        ctrl.count = fill_w;
        // offers select the oldest held entry for eviction
        ctrl.sel   = (req_type_reg == REQ_READ) ? CMP_W'(pos_reg) : fill_w - CMP_W'(1);
        ctrl.shift = upd_go && miss;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        frds_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (CMP_W'(i)),
            .ctrl       (ctrl),
            .prev_value ((i == 0) ? key_reg : cell_value[(i == 0) ? 0 : i - 1]),
            .value_out  (cell_value[i]),
            .hit_out    (cell_hit[i]),
            .pick_out   (cell_pick[i])
        );
    end

    frds_reduce u_reduce (
        .aclk       (aclk),
        .hits       (cell_hit),
        .picks      (cell_pick),
        .hit_any    (hit_any),
        .pick_value (pick_value)
    );

    always_comb begin
        was_hit         = 1'b0;
        ev_valid        = 1'b0;
        ev_value        = '0;
        en_valid        = 1'b0;
        en_value        = '0;
        fill_count_next = fill_count_reg;
        if (req_type_reg == REQ_READ) begin
            en_valid = CMP_W'(pos_reg) < fill_w;
            en_value = en_valid ? pick_value : '0;
        end else if (hit_any) begin
            was_hit = 1'b1;
        end else if (fill_w >= cap_eff) begin
            // full: push the oldest out, or the offer itself when nothing is kept
            ev_valid = 1'b1;
            ev_value = (fill_count_reg == '0) ? key_reg : pick_value;
        end else begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        m_data_next = M_DATA_W'({DATA_W'(en_value), en_valid, DATA_W'(ev_value), ev_valid,
                                 OCC_W'(fill_count_next), was_hit});
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_RED1;
            ST_RED1: state_next = ST_RED2;
            ST_RED2: state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAP_W'(256);
            fill_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (upd_go) begin
                fill_count_reg <= fill_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_type_reg <= s_tuser;
            key_reg      <= value_t'(s_tdata[DATA_W-1:0]);
            pos_reg      <= s_tdata[DATA_W +: POS_W];
        end
        if (upd_go) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `FRDS_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_CMP)
    `FRDS_ASSERT_NXT(a_upd_holds, (state_reg == ST_UPD) && !out_free, state_reg == ST_UPD)
    `FRDS_ASSERT_IMP(a_fill_bound, 1'b1, fill_count_reg <= CNT_W'(DEPTH))
    `FRDS_ASSERT_NXT(a_fill_grows, upd_go && miss && (fill_w < cap_eff), fill_count_reg == $past(fill_count_reg) + CNT_W'(1))
    `FRDS_ASSERT_NXT(a_evict_keeps, upd_go && miss && (fill_w >= cap_eff), $stable(fill_count_reg))

endmodule

`default_nettype wire

// File: rtl/frds_cell.sv
// One storage cell of the chain: holds a value, compares it to the key,
// and picks it out when its position is selected. Depends on frds_pkg.
`default_nettype none

module frds_cell (
    input  logic                   aclk,
    input  frds_pkg::cmpw_t        cell_idx,
    input  frds_pkg::cell_ctrl_t   ctrl,
    input  frds_pkg::value_t       prev_value,
    output frds_pkg::value_t       value_out,
    output logic                   hit_out,
    output frds_pkg::value_t       pick_out
);
    import frds_pkg::*;

    value_t value_reg;
    logic   hit_reg;
    value_t pick_reg;

    always_ff @(posedge aclk) begin
        // advance the chain by one place on a miss
        if (ctrl.shift) begin
            value_reg <= prev_value;
        end
        hit_reg  <= (cell_idx < ctrl.count) && (value_reg == ctrl.key);
        pick_reg <= (cell_idx == ctrl.sel) ? value_reg : '0;
    end

    assign value_out = value_reg;
    assign hit_out   = hit_reg;
    assign pick_out  = pick_reg;

endmodule

`default_nettype wire

// File: rtl/frds_reduce.sv
// Registered two-level OR tree that merges the per-cell hit flags and
// picked values into one flag and one value. Depends on frds_pkg.
`default_nettype none

module frds_reduce (
    input  logic                     aclk,
    input  logic [frds_pkg::DEPTH-1:0] hits,
    input  frds_pkg::value_t         picks [frds_pkg::DEPTH],
    output logic                     hit_any,
    output frds_pkg::value_t         pick_value
);
    import frds_pkg::*;

    logic [NGROUPS-1:0] grp_hit_next;
    logic [NGROUPS-1:0] grp_hit_reg;
    value_t             grp_pick_next [NGROUPS];
    value_t             grp_pick_reg  [NGROUPS];
    logic               hit_any_next;
    logic               hit_any_reg;
    value_t             pick_next;
    value_t             pick_reg;

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            grp_hit_next[g]  = 1'b0;
            grp_pick_next[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < DEPTH) begin
                    grp_hit_next[g]  = grp_hit_next[g] | hits[g * GROUP + k];
                    grp_pick_next[g] = grp_pick_next[g] | picks[g * GROUP + k];
                end
            end
        end
    end

    always_comb begin
        hit_any_next = |grp_hit_reg;
        pick_next    = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            pick_next = pick_next | grp_pick_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        grp_hit_reg  <= grp_hit_next;
        grp_pick_reg <= grp_pick_next;
        hit_any_reg  <= hit_any_next;
        pick_reg     <= pick_next;
    end

    assign hit_any    = hit_any_reg;
    assign pick_value = pick_reg;

endmodule

`default_nettype wire
